// ----- sv/lc3d_pkg.sv -----
// shared types and constants for the 3d leader clustering block
package lc3d_pkg;
  localparam int unsigned InCoordW = 12;
  localparam int unsigned SumW     = 28;
  localparam int unsigned CntW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    CMD_SEED   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DIST_LIMIT  = 3'd0,
    REG_BOX_EDGE    = 3'd1,
    REG_VOL_WIDTH   = 3'd2,
    REG_VOL_HEIGHT  = 3'd3,
    REG_VOL_DEPTH   = 3'd4,
    REG_MIN_MEMBERS = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] dist_limit;
    logic [11:0] box_edge;
    logic [12:0] vol_width;
    logic [12:0] vol_height;
    logic [12:0] vol_depth;
    logic [15:0] min_members;
  } cfg_t;
endpackage

// ----- sv/lc3d_if.sv -----
// valid/ready channel interfaces for input and result words
interface lc3d_in_if;
  import lc3d_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] px;
  logic [11:0] py;
  logic [11:0] pz;
  modport source (output valid, cmd, px, py, pz, input ready);
  modport sink   (input valid, cmd, px, py, pz, output ready);
endinterface

interface lc3d_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cx;
  logic [11:0] cy;
  logic [11:0] cz;
  logic [15:0] members;
  logic        empty_res;
  logic [15:0] dropped;
  logic        last;
  modport source (output valid, cx, cy, cz, members, empty_res, dropped, last, input ready);
  modport sink   (input valid, cx, cy, cz, members, empty_res, dropped, last, output ready);
endinterface

// ----- sv/leader_cluster_3d_points_core.sv -----
// top level of the 3d leader clustering block
// channels: in_ch carries command words (seed, point, finish) with x/y/z,
// out_ch carries result words of a finish, one per surviving center or one
// empty word, the final one marked last.
// configuration: cfg_we_i/cfg_idx_i/cfg_data_i write one register per edge; the user
// must write only while the block is idle, which the block itself leaves unchecked.
// a seed is written in the cycle it is taken; the next word can follow at once.
// a point reads the centers in turn, each through S_SCAN (registered read) and
// S_UPD (registered distance compared), and joins the first one in range; past the
// last center it opens a new one or, with the table full, is dropped.
// a finish averages the three sums of each center one after the other with one
// shared serial divider, then tests the averages; the last word follows the scan;
// the divider sets the finish time.
// one word is worked on at a time; in_ch.ready is low while busy.
// a survivor is held back one step so the last word can be marked; while the
// receiver stalls the finish scan holds.
// reset empties the table and the drop count; the center memory itself
// is not cleared and needs no clearing pass.
module leader_cluster_3d_points_core #(
  parameter int unsigned MAX_CENTERS = 32,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lc3d_in_if.sink                       in_ch,
  lc3d_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [lc3d_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lc3d_pkg::CfgDataW-1:0] cfg_data_i
);
  import lc3d_pkg::*;
  localparam int unsigned IdxW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int unsigned UsedW = $clog2(MAX_CENTERS + 1);
  localparam int unsigned OutCap = 32;
  localparam int unsigned NW    = $clog2(OutCap + 1);
  localparam int unsigned CW    = COORD_BITS;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef struct packed {
    logic [CW-1:0]   x, y, z;
    logic [SumW-1:0] sx, sy, sz;
    logic [CntW-1:0] n;
  } ent_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_UPD   = 8'b0000_0100,
    S_FRD   = 8'b0000_1000,
    S_FDIV  = 8'b0001_0000,
    S_FTEST = 8'b0010_0000,
    S_FOUT  = 8'b0100_0000,
    S_FEND  = 8'b1000_0000
  } state_e;

  cfg_t cfg;
  lc3d_cfg u_cfg (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg));

  ent_t mem [MAX_CENTERS];
  logic mem_we;
  logic [IdxW-1:0] wr_addr, rd_addr;
  ent_t wr_data, rd_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  state_e state_q, state_d;
  logic [UsedW-1:0] used_q, used_d, idx_q, idx_d;
  logic [CntW-1:0] drop_q, drop_d;
  logic [NW-1:0] nout_q, nout_d;
  logic [CW-1:0] px_q, py_q, pz_q;
  logic [1:0] axis_q, axis_d;
  logic [CW-1:0] avg_q [3];
  ent_t ent_q;
  logic ov_q, ov_d;
  logic [CW-1:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic [CntW-1:0] om_q, om_d;
  logic oe_q, oe_d, ol_q, ol_d;
  logic [CW-1:0] hold_x_q, hold_y_q, hold_z_q;
  logic [CntW-1:0] hold_m_q;
  logic hold_ld, out_ld;
  logic acc;

  // squared distance, one product per axis, registered before the compare
  logic [CW:0] dx, dy, dz;
  logic [2*CW+1:0] d2;
  logic [23:0] lim;
  assign dx = (px_q > rd_q.x) ? {1'b0, px_q - rd_q.x} : {1'b0, rd_q.x - px_q};
  assign dy = (py_q > rd_q.y) ? {1'b0, py_q - rd_q.y} : {1'b0, rd_q.y - py_q};
  assign dz = (pz_q > rd_q.z) ? {1'b0, pz_q - rd_q.z} : {1'b0, rd_q.z - pz_q};
  logic [2*CW+1:0] d2_q;
  logic [23:0] lim_q;
  logic hit;
  assign d2 = (2*CW+2)'(dx * dx) + (2*CW+2)'(dy * dy) + (2*CW+2)'(dz * dz);
  assign lim = cfg.dist_limit * cfg.dist_limit;

  // divider for the averages, fed from the read port on the first sum
  logic div_start, div_done;
  logic [SumW-1:0] div_num, div_quo;
  ent_t div_src;
  assign div_src = (state_q == S_FRD) ? rd_q : ent_q;
  assign div_num = (axis_d == 2'd0) ? div_src.sx : (axis_d == 2'd1) ? div_src.sy : div_src.sz;
  lc3d_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                  .den_i(div_src.n), .done_o(div_done), .quo_o(div_quo));

  function automatic logic [CW-1:0] half_move(logic [CW-1:0] c, logic [CW-1:0] p);
    logic [CW:0] d;
    d = {1'b0, p} - {1'b0, c};
    half_move = c + CW'(($signed(d) + $signed({1'b0, d[CW] & d[0]})) >>> 1);
  endfunction

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] s, logic [CW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + (SumW+1)'(v);
    sat_add = t[SumW] ? SumMax : t[SumW-1:0];
  endfunction

  function automatic logic near(logic [CW-1:0] c, logic [12:0] ext, logic [10:0] h);
    logic signed [17:0] r;
    r = $signed({5'd0, ext}) - $signed(18'(c));
    near = (18'(c) < 18'(h)) || (r < $signed({7'd0, h}));
  endfunction

  assign in_ch.ready = (state_q == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;

  ent_t seed_ent;
  always_comb begin
    seed_ent.x  = CW'(in_ch.px); seed_ent.y = CW'(in_ch.py); seed_ent.z = CW'(in_ch.pz);
    seed_ent.sx = SumW'(seed_ent.x); seed_ent.sy = SumW'(seed_ent.y);
    seed_ent.sz = SumW'(seed_ent.z);
    seed_ent.n  = CntW'(1);
  end

  always_comb begin
    state_d = state_q; used_d = used_q; idx_d = idx_q; drop_d = drop_q;
    nout_d = nout_q; axis_d = axis_q;
    ov_d = ov_q; ox_d = ox_q; oy_d = oy_q; oz_d = oz_q; om_d = om_q;
    oe_d = oe_q; ol_d = ol_q;
    hold_ld = 1'b0; out_ld = 1'b0;
    mem_we = 1'b0; wr_addr = idx_q[IdxW-1:0]; wr_data = rd_q;
    rd_addr = idx_q[IdxW-1:0]; div_start = 1'b0;
    hit = (d2_q < 26'(lim_q));
    if (out_ch.valid && out_ch.ready) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        rd_addr = '0;
        if (acc) begin
          unique case (cmd_e'(in_ch.cmd))
            CMD_SEED: begin
              if (used_q >= UsedW'(MAX_CENTERS)) begin
                if (drop_q != CntMax) drop_d = drop_q + 1'b1;
              end else begin
                mem_we = 1'b1; wr_addr = used_q[IdxW-1:0]; wr_data = seed_ent;
                used_d = used_q + 1'b1;
              end
            end
            CMD_POINT: state_d = S_SCAN;
            CMD_FINISH: begin nout_d = '0; state_d = S_FRD; end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // wait here for the registered read and the distance register
        state_d = S_UPD;
      end
      S_UPD: begin
        if (idx_q >= used_q) begin
          if (used_q >= UsedW'(MAX_CENTERS)) begin
            if (drop_q != CntMax) drop_d = drop_q + 1'b1;
          end else begin
            mem_we = 1'b1; wr_addr = used_q[IdxW-1:0];
            wr_data.x = px_q; wr_data.y = py_q; wr_data.z = pz_q;
            wr_data.sx = SumW'(px_q); wr_data.sy = SumW'(py_q); wr_data.sz = SumW'(pz_q);
            wr_data.n = CntW'(1);
            used_d = used_q + 1'b1;
          end
          state_d = S_IDLE;
        end else if (hit) begin
          mem_we = 1'b1;
          wr_data.x = half_move(ent_q.x, px_q);
          wr_data.y = half_move(ent_q.y, py_q);
          wr_data.z = half_move(ent_q.z, pz_q);
          wr_data.sx = sat_add(ent_q.sx, px_q);
          wr_data.sy = sat_add(ent_q.sy, py_q);
          wr_data.sz = sat_add(ent_q.sz, pz_q);
          wr_data.n = (ent_q.n != CntMax) ? ent_q.n + 1'b1 : ent_q.n;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
          rd_addr = IdxW'(idx_q + 1'b1);
          state_d = S_SCAN;
        end
      end
      S_FRD: begin
        if (idx_q >= used_q) state_d = S_FEND;
        else begin
          axis_d = 2'd0;
          state_d = S_FDIV;
          div_start = 1'b1;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          if (axis_q == 2'd2) state_d = S_FTEST;
          else begin
            axis_d = axis_q + 1'b1;
            div_start = 1'b1;
          end
        end
      end
      S_FTEST: begin
        if (near(avg_q[0], cfg.vol_width, cfg.box_edge[11:1]) ||
            near(avg_q[1], cfg.vol_height, cfg.box_edge[11:1]) ||
            near(avg_q[2], cfg.vol_depth, cfg.box_edge[11:1]) ||
            (ent_q.n < cfg.min_members) || (nout_q >= NW'(OutCap))) begin
          idx_d = idx_q + 1'b1;
          rd_addr = IdxW'(idx_q + 1'b1);
          state_d = S_FRD;
        end else state_d = S_FOUT;
      end
      S_FOUT: begin
        // the held survivor goes out once a newer one shows it is not last
        if (nout_q == '0 || !ov_q || out_ch.ready) begin
          if (nout_q != '0) begin
            out_ld = 1'b1;
            ov_d = 1'b1; ol_d = 1'b0; oe_d = 1'b0;
            ox_d = hold_x_q; oy_d = hold_y_q; oz_d = hold_z_q; om_d = hold_m_q;
          end
          hold_ld = 1'b1;
          nout_d = nout_q + 1'b1;
          idx_d = idx_q + 1'b1;
          rd_addr = IdxW'(idx_q + 1'b1);
          state_d = S_FRD;
        end
      end
      S_FEND: begin
        if (!ov_q || out_ch.ready) begin
          out_ld = 1'b1;
          ov_d = 1'b1; ol_d = 1'b1;
          if (nout_q == '0) begin
            ox_d = '0; oy_d = '0; oz_d = '0; om_d = '0; oe_d = 1'b1;
          end else begin
            ox_d = hold_x_q; oy_d = hold_y_q; oz_d = hold_z_q; om_d = hold_m_q;
            oe_d = 1'b0;
          end
          used_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; idx_q <= '0; drop_q <= '0;
      nout_q <= '0; axis_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; idx_q <= idx_d;
      drop_q <= (state_q == S_FEND && state_d == S_IDLE) ? '0 : drop_d;
      nout_q <= nout_d; axis_q <= axis_d; ov_q <= ov_d;
    end
  end

  logic [CntW-1:0] od_q;
  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q <= CW'(in_ch.px); py_q <= CW'(in_ch.py); pz_q <= CW'(in_ch.pz);
    end
    d2_q <= d2;
    lim_q <= lim;
    if (state_q == S_SCAN || state_q == S_FRD) ent_q <= rd_q;
    if (div_done) avg_q[axis_q] <= (div_quo > SumW'({CW{1'b1}})) ? {CW{1'b1}} : CW'(div_quo);
    if (hold_ld) begin
      hold_x_q <= avg_q[0]; hold_y_q <= avg_q[1]; hold_z_q <= avg_q[2]; hold_m_q <= ent_q.n;
    end
    ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d; om_q <= om_d; oe_q <= oe_d; ol_q <= ol_d;
    if (out_ld) od_q <= drop_q;
  end

  assign out_ch.valid     = ov_q;
  assign out_ch.cx        = 12'(ox_q);
  assign out_ch.cy        = 12'(oy_q);
  assign out_ch.cz        = 12'(oz_q);
  assign out_ch.members   = om_q;
  assign out_ch.empty_res = oe_q;
  assign out_ch.dropped   = od_q;
  assign out_ch.last      = ol_q;
endmodule

// ----- sv/lc3d_cfg.sv -----
// configuration register file
module lc3d_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lc3d_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lc3d_pkg::CfgDataW-1:0]  cfg_data_i,
  output lc3d_pkg::cfg_t                 cfg_o
);
  import lc3d_pkg::*;
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dist_limit  <= 12'd10;
      cfg_q.box_edge    <= 12'd32;
      cfg_q.vol_width   <= 13'd512;
      cfg_q.vol_height  <= 13'd512;
      cfg_q.vol_depth   <= 13'd256;
      cfg_q.min_members <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIST_LIMIT:  cfg_q.dist_limit  <= cfg_data_i[11:0];
        REG_BOX_EDGE:    cfg_q.box_edge    <= cfg_data_i[11:0];
        REG_VOL_WIDTH:   cfg_q.vol_width   <= cfg_data_i[12:0];
        REG_VOL_HEIGHT:  cfg_q.vol_height  <= cfg_data_i[12:0];
        REG_VOL_DEPTH:   cfg_q.vol_depth   <= cfg_data_i[12:0];
        REG_MIN_MEMBERS: cfg_q.min_members <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule

// ----- sv/lc3d_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module lc3d_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lc3d_pkg::SumW-1:0]    num_i,
  input  logic [lc3d_pkg::CntW-1:0]    den_i,
  output logic                         done_o,
  output logic [lc3d_pkg::SumW-1:0]    quo_o
);
  import lc3d_pkg::*;
  localparam int unsigned StepW = $clog2(SumW + 1);
  logic [StepW-1:0] step_q, step_d;
  logic busy_q, busy_d;
  logic [SumW-1:0] quo_q, quo_d, quo_nx;
  logic [CntW:0] rem_q, rem_d, trial, rem_nx;
  logic [CntW-1:0] den_q;

  always_comb begin
    trial  = {rem_q[CntW-1:0], quo_q[SumW-1]};
    quo_nx = {quo_q[SumW-2:0], 1'b0};
    rem_nx = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_nx    = trial - {1'b0, den_q};
      quo_nx[0] = 1'b1;
    end
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(SumW);
      quo_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d  = quo_nx;
      rem_d  = rem_nx;
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end
  assign done_o = busy_q && (step_q == StepW'(1));
  assign quo_o  = quo_nx;
endmodule

// ----- verif/tb_top.sv -----
// testbench for the 3d leader clustering core: directed and random words, checked against a model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lc3d_pkg::*;

  typedef struct packed {
    logic [11:0] cx;
    logic [11:0] cy;
    logic [11:0] cz;
    logic [15:0] members;
    logic        empty_res;
    logic [15:0] dropped;
    logic        last;
  } centroid_t;

  localparam int unsigned NumCenters = 32;
  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  lc3d_in_if in_ch ();
  lc3d_out_if out_ch ();

  leader_cluster_3d_points_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  cfg_t cfg;
  logic [11:0] ctr_x [NumCenters];
  logic [11:0] ctr_y [NumCenters];
  logic [11:0] ctr_z [NumCenters];
  logic [27:0] sum_x [NumCenters];
  logic [27:0] sum_y [NumCenters];
  logic [27:0] sum_z [NumCenters];
  logic [15:0] n_mem [NumCenters];
  int unsigned n_used;
  logic [15:0] n_lost;

  centroid_t centroid_q[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic logic [27:0] sat_sum(logic [27:0] s, logic [11:0] v);
    logic [28:0] t;
    t = s + v;
    return t[28] ? 28'hFFFFFFF : t[27:0];
  endfunction

  function automatic logic [11:0] halfway(logic [11:0] c, logic [11:0] p);
    int d;
    d = int'(p) - int'(c);
    return 12'(int'(c) + d / 2);
  endfunction

  function automatic logic [11:0] mean(logic [27:0] s, logic [15:0] n);
    logic [27:0] a;
    if (n == 0) return 12'd0;
    a = s / n;
    return (a > 28'd4095) ? 12'hFFF : a[11:0];
  endfunction

  function automatic bit at_border(logic [11:0] c, logic [12:0] ext, int half);
    return (int'(c) < half) || ((int'(ext) - int'(c)) < half);
  endfunction

  task automatic open_center(logic [11:0] x, logic [11:0] y, logic [11:0] z);
    if (n_used >= NumCenters) begin
      if (n_lost != 16'hFFFF) n_lost++;
      return;
    end
    ctr_x[n_used] = x; ctr_y[n_used] = y; ctr_z[n_used] = z;
    sum_x[n_used] = x; sum_y[n_used] = y; sum_z[n_used] = z;
    n_mem[n_used] = 16'd1;
    n_used++;
  endtask

  task automatic cluster_step(cmd_e cmd, logic [11:0] x, logic [11:0] y, logic [11:0] z);
    longint lim, d2, dx, dy, dz;
    int half, n;
    centroid_t r, res[$];
    lim = longint'(cfg.dist_limit) * cfg.dist_limit;
    unique case (cmd)
      CMD_SEED: open_center(x, y, z);
      CMD_POINT: begin
        for (int j = 0; j < n_used; j++) begin
          dx = longint'(x) - ctr_x[j]; dy = longint'(y) - ctr_y[j];
          dz = longint'(z) - ctr_z[j];
          d2 = dx * dx + dy * dy + dz * dz;
          if (d2 < lim) begin
            ctr_x[j] = halfway(ctr_x[j], x);
            ctr_y[j] = halfway(ctr_y[j], y);
            ctr_z[j] = halfway(ctr_z[j], z);
            sum_x[j] = sat_sum(sum_x[j], x);
            sum_y[j] = sat_sum(sum_y[j], y);
            sum_z[j] = sat_sum(sum_z[j], z);
            if (n_mem[j] != 16'hFFFF) n_mem[j]++;
            return;
          end
        end
        open_center(x, y, z);
      end
      CMD_FINISH: begin
        half = cfg.box_edge / 2;
        for (int j = 0; j < n_used; j++) begin
          r = '0;
          r.cx = mean(sum_x[j], n_mem[j]);
          r.cy = mean(sum_y[j], n_mem[j]);
          r.cz = mean(sum_z[j], n_mem[j]);
          if (at_border(r.cx, cfg.vol_width, half) || at_border(r.cy, cfg.vol_height, half) ||
              at_border(r.cz, cfg.vol_depth, half)) continue;
          if (n_mem[j] < cfg.min_members) continue;
          r.members = n_mem[j];
          r.dropped = n_lost;
          res = {res, r};
        end
        if (res.size() == 0) begin
          r = '0;
          r.empty_res = 1'b1;
          r.dropped = n_lost;
          res = {res, r};
        end
        n = res.size();
        res[n - 1].last = 1'b1;
        centroid_q = {centroid_q, res};
        n_used = 0;
        n_lost = '0;
      end
      default: ;
    endcase
  endtask

  // idle driving
  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NONE;
    in_ch.px = '0; in_ch.py = '0; in_ch.pz = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(cmd_e cmd, logic [11:0] x, logic [11:0] y, logic [11:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.px <= x; in_ch.py <= y; in_ch.pz <= z;
    do @(posedge clk_i); while (!in_ch.ready);
    cluster_step(cmd, x, y, z);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (centroid_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(negedge clk_i);
    unique case (idx)
      REG_DIST_LIMIT:  cfg.dist_limit = 12'(val);
      REG_BOX_EDGE:    cfg.box_edge = 12'(val);
      REG_VOL_WIDTH:   cfg.vol_width = 13'(val);
      REG_VOL_HEIGHT:  cfg.vol_height = 13'(val);
      REG_VOL_DEPTH:   cfg.vol_depth = 13'(val);
      REG_MIN_MEMBERS: cfg.min_members = 16'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned dl, int unsigned be, int unsigned w, int unsigned h,
                            int unsigned d, int unsigned mm);
    wait_drained();
    write_reg(REG_DIST_LIMIT, dl);
    write_reg(REG_BOX_EDGE, be);
    write_reg(REG_VOL_WIDTH, w);
    write_reg(REG_VOL_HEIGHT, h);
    write_reg(REG_VOL_DEPTH, d);
    write_reg(REG_MIN_MEMBERS, mm);
    cfg_we_i <= 1'b0;
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin
    centroid_t got, want;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cx, out_ch.cy, out_ch.cz, out_ch.members, out_ch.empty_res,
                out_ch.dropped, out_ch.last};
        if (centroid_q.size() == 0) begin
          $display("%0t: unexpected word %p", $time, got);
          errors++;
        end else begin
          want = centroid_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_word(CMD_SEED, 12'd100, 12'd100, 12'd100);
    for (int i = 0; i < 11; i++)
      send_word(CMD_POINT, 12'(100 + i % 3), 12'(99 + i % 2), 12'd101);
    send_word(CMD_POINT, 12'd300, 12'd200, 12'd128);
    send_word(CMD_NONE, 12'hFFF, 12'hFFF, 12'hFFF);
    send_word(CMD_FINISH, 12'd0, 12'd0, 12'd0);
    send_word(CMD_FINISH, 12'hFFF, 12'hFFF, 12'hFFF);
  endtask

  task automatic test_extremes();
    set_config(4095, 0, 4096, 4096, 4096, 0);
    send_word(CMD_SEED, 12'd0, 12'd0, 12'd0);
    send_word(CMD_POINT, 12'hFFF, 12'hFFF, 12'hFFF);
    send_word(CMD_POINT, 12'hFFF, 12'd0, 12'hFFF);
    send_word(CMD_FINISH, 12'd0, 12'd0, 12'd0);
    set_config(0, 4095, 1, 1, 1, 65535);
    send_word(CMD_POINT, 12'd5, 12'd5, 12'd5);
    send_word(CMD_FINISH, 12'd0, 12'd0, 12'd0);
  endtask

  task automatic test_table_full();
    set_config(1, 2, 4096, 4096, 4096, 1);
    for (int i = 0; i < 36; i++)
      send_word((i % 2) ? CMD_POINT : CMD_SEED, 12'(i * 100 + 50), 12'(i * 37 + 9), 12'd2000);
    send_word(CMD_FINISH, 12'd0, 12'd0, 12'd0);
  endtask

  task automatic random_round(int unsigned n_words);
    logic [11:0] bx, by, bz;
    int unsigned sp, k;
    bx = 12'($urandom); by = 12'($urandom); bz = 12'($urandom);
    sp = $urandom_range(1, 40);
    for (int i = 0; i < n_words; i++) begin
      k = $urandom_range(99);
      if (k < 8) begin
        bx = 12'($urandom); by = 12'($urandom); bz = 12'($urandom);
        send_word(CMD_SEED, bx, by, bz);
      end else if (k < 85)
        send_word(CMD_POINT, 12'(bx + $urandom_range(0, 2 * sp) - sp),
                  12'(by + $urandom_range(0, 2 * sp) - sp),
                  12'(bz + $urandom_range(0, 2 * sp) - sp));
      else if (k < 95)
        send_word(CMD_POINT, 12'($urandom), 12'($urandom), 12'($urandom));
      else
        send_word(CMD_NONE, 12'($urandom), 12'($urandom), 12'($urandom));
    end
    send_word(CMD_FINISH, 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic test_random(int unsigned rounds);
    for (int r = 0; r < rounds; r++) begin
      if (r % 4 == 0)
        set_config($urandom_range(4, 300), $urandom_range(0, 600), $urandom_range(1, 4096),
                   $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 8));
      random_round($urandom_range(5, 32));
    end
  endtask

  initial begin
    cfg = '{12'd10, 12'd32, 13'd512, 13'd512, 13'd256, 16'd10};
    n_used = 0;
    n_lost = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_extremes();
    test_table_full();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(4);
    send_idle_pct = 48; recv_stall_pct = 0;  test_random(4);
    send_idle_pct = 0;  recv_stall_pct = 48; test_random(4);
    send_idle_pct = 25; recv_stall_pct = 25; test_random(4);
    wait_drained();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/lc3d_pkg.sv
sv/lc3d_if.sv
sv/lc3d_cfg.sv
sv/lc3d_div.sv
sv/leader_cluster_3d_points_core.sv
verif/tb_top.sv
